### src/arp_resolver_with_pending_queue_unit_assert.svh
// Assertion macros for the ARP resolver.
// Each expects clk and rst_n to be in scope where it is used.
`ifndef ARP_RESOLVER_WITH_PENDING_QUEUE_UNIT_ASSERT_SVH
`define ARP_RESOLVER_WITH_PENDING_QUEUE_UNIT_ASSERT_SVH

// condition in the same cycle
`define ARPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition in the following cycle
`define ARPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/arpr_pkg.sv
// Shared types and constants of the ARP resolver.
// No dependencies; used by all modules of the block.
package arpr_pkg;

  localparam int MAC_W     = 48;
  localparam int IP_W      = 32;
  localparam int TIME_W    = 32;
  localparam int TAG_W     = 16;
  localparam int ELAPSED_W = 16;
  localparam int CFG_IDX_W = 2;

  // item actions
  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_ARP  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_IPV4    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_REPLY   = 2'd2;
  localparam logic [1:0] KIND_DROP    = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF  = 2'd3;

  localparam logic [TIME_W-1:0] LIFETIME_RST = 32'd30000;
  localparam logic [TIME_W-1:0] HOLDOFF_RST  = 32'd5000;
  localparam logic [MAC_W-1:0]  MAC_BCAST    = '1;

  typedef struct packed {
    logic [1:0]           action;
    logic [IP_W-1:0]      hop_ip;
    logic [TAG_W-1:0]     datagram_tag;
    logic [MAC_W-1:0]     frame_dst_mac;
    logic                 arp_is_reply;
    logic [IP_W-1:0]      sender_ip;
    logic [MAC_W-1:0]     sender_mac;
    logic [IP_W-1:0]      target_ip;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       frame_kind;
    logic [MAC_W-1:0] dst_mac;
    logic [IP_W-1:0]  arp_target_ip;
    logic [MAC_W-1:0] arp_target_mac;
    logic [TAG_W-1:0] out_tag;
    logic             last;
  } out_item_t;

  // control from the sequencer to the output stage
  typedef struct packed {
    logic      emit;
    logic      finish;
    out_item_t item;
  } emit_t;

endpackage

### src/arpr_out_stage.sv
// Output stage of the ARP resolver: holds one result back so the last flag
// is known when it leaves. Depends on arpr_pkg.
module arpr_out_stage import arpr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  emit_t     ctl,
  output logic      out_valid,
  output out_item_t out_item
);

  logic      pend_vld_r;
  out_item_t pend_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t held;

  // held item leaves with last set only when the sequencer finishes
  always_comb begin
    held      = pend_r;
    held.last = ctl.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.emit || ctl.finish) begin
        out_valid_r <= pend_vld_r;
        out_item_r  <= held;
      end else begin
        out_valid_r <= 1'b0;
      end
      if (ctl.emit) begin
        pend_r     <= ctl.item;
        pend_vld_r <= 1'b1;
      end else if (ctl.finish) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### src/arp_resolver_with_pending_queue_unit.sv
// ARP resolver. An item is taken when start is high and busy is low. Busy
// then stays high while the item is worked: a tick or a send scans the
// cache, a send that misses then pushes to the pending queue and scans the
// request table, a matching ARP item scans the cache, learns the sender and
// scans the queue, and an ignored item goes straight to the done state;
// each scan reads its memory through that memory's one read port. Results
// appear on out_item for one cycle each, flagged by out_valid, with
// out_item.last on the final one; the receiver cannot stall them. A result
// leaves the cycle after the next one is formed; the last is on the output
// in the first cycle in which busy is low.
module arp_resolver_with_pending_queue_unit import arpr_pkg::*; #(
  parameter int CACHE_ENTRIES   = 16,
  parameter int REQUEST_ENTRIES = 8,
  parameter int QUEUE_ENTRIES   = 16,
  parameter int TAG_BITS        = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAC_W-1:0]     cfg_wdata
);

  `include "arp_resolver_with_pending_queue_unit_assert.svh"

  localparam int CAW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CCW = $clog2(CACHE_ENTRIES + 1);
  localparam int RAW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
  localparam int RCW = $clog2(REQUEST_ENTRIES + 1);
  localparam int QAW = (QUEUE_ENTRIES > 1) ? $clog2(QUEUE_ENTRIES) : 1;
  localparam int QCW = $clog2(QUEUE_ENTRIES + 1);
  localparam int SCW = (CCW > RCW) ? ((CCW > QCW) ? CCW : QCW)
                                   : ((RCW > QCW) ? RCW : QCW);

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] stamp;
  } cache_ent_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [TIME_W-1:0] stamp;
  } req_ent_t;

  typedef struct packed {
    logic [IP_W-1:0]     ip;
    logic [TAG_BITS-1:0] tag;
  } q_ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CSCAN, S_LEARN_WR, S_QPUSH, S_RSCAN, S_RDEC, S_FSCAN, S_FEND, S_DONE
  } state_t;

  state_t state_r;
  logic [1:0]        act_r;
  in_item_t          item_r;
  logic [TIME_W-1:0] now_r;
  logic [MAC_W-1:0]  own_mac_r;
  logic [IP_W-1:0]   own_ip_r;
  logic [TIME_W-1:0] lifetime_r;
  logic [TIME_W-1:0] holdoff_r;

  logic [CACHE_ENTRIES-1:0]   cache_vld_r;
  logic [REQUEST_ENTRIES-1:0] req_vld_r;
  logic [QCW-1:0]             q_cnt_r;
  logic [QCW-1:0]             w_r;

  // scan pipeline
  logic [SCW-1:0] idx_r, ck_r, scan_lim;
  logic           rv_r, scanning, issue, scan_end;

  // cache scan results
  logic              hit_r, free_r;
  logic [CAW-1:0]    hit_idx_r, free_idx_r, best_idx_r;
  logic [MAC_W-1:0]  hit_mac_r;
  logic [TIME_W-1:0] best_age_r;

  // request scan results
  logic              rm_r, rf_r;
  logic [RAW-1:0]    rm_idx_r, rf_idx_r, rb_idx_r;
  logic [TIME_W-1:0] rm_age_r, rb_age_r;

  // memories
  cache_ent_t cache_mem [CACHE_ENTRIES];
  req_ent_t   req_mem   [REQUEST_ENTRIES];
  q_ent_t     q_mem     [QUEUE_ENTRIES];
  cache_ent_t c_rd_r, c_wd;
  req_ent_t   r_rd_r, r_wd;
  q_ent_t     q_rd_r, q_wd;
  logic           c_we, c_re, r_we, r_re, q_we, q_re;
  logic [CAW-1:0] c_wa, c_ck, learn_slot;
  logic [RAW-1:0] r_wa, r_ck, r_slot;
  logic [QAW-1:0] q_wa;

  logic [IP_W-1:0]     key_ip;
  logic [TAG_BITS-1:0] tag_k;
  logic [TIME_W-1:0]   c_age, r_age;
  logic                c_match, r_match, q_full, req_emit, arp_hit;
  emit_t               ctl;

  assign busy     = (state_r != S_IDLE);
  assign key_ip   = (act_r == ACT_SEND) ? item_r.hop_ip : item_r.sender_ip;
  assign tag_k    = TAG_BITS'(item_r.datagram_tag);
  assign c_ck     = ck_r[CAW-1:0];
  assign r_ck     = ck_r[RAW-1:0];
  assign c_age    = now_r - c_rd_r.stamp;
  assign r_age    = now_r - r_rd_r.stamp;
  assign c_match  = cache_vld_r[c_ck] && (c_rd_r.ip == key_ip);
  assign r_match  = req_vld_r[r_ck] && (r_rd_r.ip == key_ip);
  assign q_full   = (q_cnt_r == QCW'(QUEUE_ENTRIES));
  assign req_emit = !(rm_r && (rm_age_r <= holdoff_r));
  assign arp_hit  = ((in_item.frame_dst_mac == own_mac_r) ||
                     (in_item.frame_dst_mac == MAC_BCAST)) &&
                    (in_item.target_ip == own_ip_r);

  assign learn_slot = hit_r ? hit_idx_r : (free_r ? free_idx_r : best_idx_r);
  assign r_slot     = rm_r ? rm_idx_r : (rf_r ? rf_idx_r : rb_idx_r);

  // scan issue: one read per cycle, data checked the cycle after
  always_comb begin
    scanning = 1'b0;
    scan_lim = '0;
    case (state_r)
      S_CSCAN: begin
        scanning = 1'b1;
        scan_lim = SCW'(CACHE_ENTRIES);
      end
      S_RSCAN: begin
        scanning = 1'b1;
        scan_lim = SCW'(REQUEST_ENTRIES);
      end
      S_FSCAN: begin
        scanning = 1'b1;
        scan_lim = SCW'(q_cnt_r);
      end
      default: ;
    endcase
    issue    = scanning && (idx_r < scan_lim);
    scan_end = scanning && !issue && !rv_r;
    c_re     = issue && (state_r == S_CSCAN);
    r_re     = issue && (state_r == S_RSCAN);
    q_re     = issue && (state_r == S_FSCAN);
  end

  // memory writes and result emission
  always_comb begin
    c_we = (state_r == S_LEARN_WR);
    c_wa = learn_slot;
    c_wd = '{ip: item_r.sender_ip, mac: item_r.sender_mac, stamp: now_r};
    r_we = (state_r == S_RDEC) && req_emit;
    r_wa = r_slot;
    r_wd = '{ip: key_ip, stamp: now_r};
    if (state_r == S_QPUSH) begin
      q_we = !q_full;
      q_wa = q_cnt_r[QAW-1:0];
      q_wd = '{ip: key_ip, tag: tag_k};
    end else begin
      q_we = (state_r == S_FSCAN) && rv_r && (q_rd_r.ip != key_ip);
      q_wa = w_r[QAW-1:0];
      q_wd = q_rd_r;
    end

    ctl = '0;
    case (state_r)
      S_CSCAN: begin
        if (scan_end && (act_r == ACT_SEND) && hit_r) begin
          ctl.emit            = 1'b1;
          ctl.item.frame_kind = KIND_IPV4;
          ctl.item.dst_mac    = hit_mac_r;
          ctl.item.out_tag    = TAG_W'(tag_k);
        end
      end
      S_QPUSH: begin
        if (q_full) begin
          ctl.emit            = 1'b1;
          ctl.item.frame_kind = KIND_DROP;
          ctl.item.out_tag    = TAG_W'(tag_k);
        end
      end
      S_RDEC: begin
        if (req_emit) begin
          ctl.emit               = 1'b1;
          ctl.item.frame_kind    = KIND_REQUEST;
          ctl.item.dst_mac       = MAC_BCAST;
          ctl.item.arp_target_ip = key_ip;
        end
      end
      S_FSCAN: begin
        if (rv_r && (q_rd_r.ip == key_ip)) begin
          ctl.emit            = 1'b1;
          ctl.item.frame_kind = KIND_IPV4;
          ctl.item.dst_mac    = item_r.sender_mac;
          ctl.item.out_tag    = TAG_W'(q_rd_r.tag);
        end
      end
      S_FEND: begin
        ctl.emit                = 1'b1;
        ctl.item.frame_kind     = KIND_REPLY;
        ctl.item.dst_mac        = item_r.sender_mac;
        ctl.item.arp_target_ip  = item_r.sender_ip;
        ctl.item.arp_target_mac = item_r.sender_mac;
      end
      S_DONE:  ctl.finish = 1'b1;
      default: ;
    endcase
  end

  // cache memory
  always_ff @(posedge clk) begin
    if (c_we) cache_mem[c_wa] <= c_wd;
    if (c_re) c_rd_r <= cache_mem[idx_r[CAW-1:0]];
  end

  // request table memory
  always_ff @(posedge clk) begin
    if (r_we) req_mem[r_wa] <= r_wd;
    if (r_re) r_rd_r <= req_mem[idx_r[RAW-1:0]];
  end

  // pending queue memory
  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_rd_r <= q_mem[idx_r[QAW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      now_r       <= '0;
      own_mac_r   <= '0;
      own_ip_r    <= '0;
      lifetime_r  <= LIFETIME_RST;
      holdoff_r   <= HOLDOFF_RST;
      cache_vld_r <= '0;
      req_vld_r   <= '0;
      q_cnt_r     <= '0;
      idx_r       <= '0;
      rv_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OWN_MAC:  own_mac_r  <= cfg_wdata;
          CFG_OWN_IP:   own_ip_r   <= cfg_wdata[IP_W-1:0];
          CFG_LIFETIME: lifetime_r <= cfg_wdata[TIME_W-1:0];
          CFG_HOLDOFF:  holdoff_r  <= cfg_wdata[TIME_W-1:0];
          default: ;
        endcase
      end

      rv_r <= issue;
      ck_r <= idx_r;
      if (issue) idx_r <= idx_r + SCW'(1);

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r     <= in_item;
            act_r      <= in_item.action;
            idx_r      <= '0;
            hit_r      <= 1'b0;
            free_r     <= 1'b0;
            best_age_r <= '0;
            best_idx_r <= '0;
            rm_r       <= 1'b0;
            rf_r       <= 1'b0;
            rb_age_r   <= '0;
            rb_idx_r   <= '0;
            w_r        <= '0;
            case (in_item.action)
              ACT_SEND: state_r <= S_CSCAN;
              ACT_ARP:  state_r <= arp_hit ? S_CSCAN : S_DONE;
              ACT_TICK: begin
                now_r   <= now_r + TIME_W'(in_item.elapsed_ms);
                state_r <= S_CSCAN;
              end
              default:  state_r <= S_DONE;
            endcase
          end
        end
        S_CSCAN: begin
          if (rv_r) begin
            if (act_r == ACT_TICK) begin
              if (cache_vld_r[c_ck] && (c_age >= lifetime_r)) cache_vld_r[c_ck] <= 1'b0;
            end else begin
              if (c_match && !hit_r) begin
                hit_r     <= 1'b1;
                hit_idx_r <= c_ck;
                hit_mac_r <= c_rd_r.mac;
              end
              if (!cache_vld_r[c_ck] && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= c_ck;
              end
              if (c_age > best_age_r) begin
                best_age_r <= c_age;
                best_idx_r <= c_ck;
              end
            end
          end
          if (scan_end) begin
            if (act_r == ACT_SEND)     state_r <= hit_r ? S_DONE : S_QPUSH;
            else if (act_r == ACT_ARP) state_r <= S_LEARN_WR;
            else                       state_r <= S_DONE;
          end
        end
        S_LEARN_WR: begin
          cache_vld_r[learn_slot] <= 1'b1;
          idx_r   <= '0;
          state_r <= S_FSCAN;
        end
        S_QPUSH: begin
          if (!q_full) q_cnt_r <= q_cnt_r + QCW'(1);
          idx_r   <= '0;
          state_r <= S_RSCAN;
        end
        S_RSCAN: begin
          if (rv_r) begin
            if (r_match && !rm_r) begin
              rm_r     <= 1'b1;
              rm_idx_r <= r_ck;
              rm_age_r <= r_age;
            end
            if (!req_vld_r[r_ck] && !rf_r) begin
              rf_r     <= 1'b1;
              rf_idx_r <= r_ck;
            end
            if (r_age > rb_age_r) begin
              rb_age_r <= r_age;
              rb_idx_r <= r_ck;
            end
          end
          if (scan_end) state_r <= S_RDEC;
        end
        S_RDEC: begin
          if (req_emit) req_vld_r[r_slot] <= 1'b1;
          state_r <= S_DONE;
        end
        S_FSCAN: begin
          // kept entries slide down to the write pointer
          if (rv_r && (q_rd_r.ip != key_ip)) w_r <= w_r + QCW'(1);
          if (scan_end) begin
            q_cnt_r <= w_r;
            state_r <= item_r.arp_is_reply ? S_DONE : S_FEND;
          end
        end
        S_FEND:  state_r <= S_DONE;
        S_DONE:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  arpr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `ARPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `ARPR_ASSERT_NEXT(a_done_idle, state_r == S_DONE, !busy, "busy after finishing an item")
  `ARPR_ASSERT_NOW(a_q_bound, 1'b1, q_cnt_r <= QCW'(QUEUE_ENTRIES), "queue count overflow")
  `ARPR_ASSERT_NOW(a_last_after_done, out_valid && out_item.last, $past(state_r == S_DONE),
    "last result not at end of item")

endmodule

### sim/arp_resolver_with_pending_queue_checker.sv
// Checker for the ARP resolver: predicts results of every accepted item and
// compares them with the result port. Depends on arpr_pkg.
module arp_resolver_with_pending_queue_checker import arpr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAC_W-1:0]     cfg_wdata,
  output int                   fails,
  output int                   pending
);

  localparam int N_CACHE = 16;
  localparam int N_REQ   = 8;
  localparam int N_QUEUE = 16;

  // shadow configuration
  logic [MAC_W-1:0]  my_mac;
  logic [IP_W-1:0]   my_ip;
  logic [TIME_W-1:0] lifetime;
  logic [TIME_W-1:0] holdoff;

  // shadow state
  logic [TIME_W-1:0] clock_ms;
  bit                arp_vld [N_CACHE];
  logic [IP_W-1:0]   arp_ip  [N_CACHE];
  logic [MAC_W-1:0]  arp_mac [N_CACHE];
  logic [TIME_W-1:0] arp_time[N_CACHE];
  bit                req_vld [N_REQ];
  logic [IP_W-1:0]   req_ip  [N_REQ];
  logic [TIME_W-1:0] req_time[N_REQ];
  bit                wait_vld[N_QUEUE];
  logic [IP_W-1:0]   wait_ip [N_QUEUE];
  logic [TAG_W-1:0]  wait_tag[N_QUEUE];

  out_item_t frames_due[$];
  int        fail_cnt;

  function automatic out_item_t frame(logic [1:0] kind, logic [MAC_W-1:0] dmac,
                                      logic [IP_W-1:0] tip, logic [MAC_W-1:0] tmac,
                                      logic [TAG_W-1:0] tag);
    out_item_t f;
    f.frame_kind     = kind;
    f.dst_mac        = dmac;
    f.arp_target_ip  = tip;
    f.arp_target_mac = tmac;
    f.out_tag        = tag;
    f.last           = 1'b0;
    return f;
  endfunction

  task automatic reset_shadow();
    my_mac   = '0;
    my_ip    = '0;
    lifetime = LIFETIME_RST;
    holdoff  = HOLDOFF_RST;
    clock_ms = '0;
    foreach (arp_vld[i])  arp_vld[i]  = 0;
    foreach (req_vld[i])  req_vld[i]  = 0;
    foreach (wait_vld[i]) wait_vld[i] = 0;
    frames_due.delete();
  endtask

  // work out the frames caused by one item and queue them in order
  task automatic resolve_item(input in_item_t it);
    out_item_t         res[$];
    int                hit, slot, w;
    logic [TIME_W-1:0] best, age;
    hit = -1;
    slot = -1;
    if (it.action == ACT_SEND) begin
      foreach (arp_vld[i])
        if (hit < 0 && arp_vld[i] && arp_ip[i] == it.hop_ip) hit = i;
      if (hit >= 0) begin
        res = {res, frame(KIND_IPV4, arp_mac[hit], '0, '0, it.datagram_tag)};
      end else begin
        foreach (wait_vld[i])
          if (slot < 0 && !wait_vld[i]) slot = i;
        if (slot < 0) begin
          res = {res, frame(KIND_DROP, '0, '0, '0, it.datagram_tag)};
        end else begin
          wait_vld[slot] = 1;
          wait_ip[slot]  = it.hop_ip;
          wait_tag[slot] = it.datagram_tag;
        end
        // request unless one went out within the holdoff
        slot = -1;
        foreach (req_vld[i])
          if (slot < 0 && req_vld[i] && req_ip[i] == it.hop_ip) slot = i;
        if (slot < 0 || clock_ms - req_time[slot] > holdoff) begin
          if (slot < 0)
            foreach (req_vld[i])
              if (slot < 0 && !req_vld[i]) slot = i;
          if (slot < 0) begin
            slot = 0;
            best = '0;
            foreach (req_vld[i]) begin
              age = clock_ms - req_time[i];
              if (age > best) begin
                best = age;
                slot = i;
              end
            end
          end
          res = {res, frame(KIND_REQUEST, MAC_BCAST, it.hop_ip, '0, '0)};
          req_vld[slot]  = 1;
          req_ip[slot]   = it.hop_ip;
          req_time[slot] = clock_ms;
        end
      end
    end else if (it.action == ACT_ARP) begin
      if ((it.frame_dst_mac == my_mac || it.frame_dst_mac == MAC_BCAST) &&
          it.target_ip == my_ip) begin
        // learn: same IP, else free entry, else oldest
        foreach (arp_vld[i])
          if (slot < 0 && arp_vld[i] && arp_ip[i] == it.sender_ip) slot = i;
        if (slot < 0)
          foreach (arp_vld[i])
            if (slot < 0 && !arp_vld[i]) slot = i;
        if (slot < 0) begin
          slot = 0;
          best = '0;
          foreach (arp_vld[i]) begin
            age = clock_ms - arp_time[i];
            if (age > best) begin
              best = age;
              slot = i;
            end
          end
        end
        arp_vld[slot]  = 1;
        arp_ip[slot]   = it.sender_ip;
        arp_mac[slot]  = it.sender_mac;
        arp_time[slot] = clock_ms;
        // flush waiting tags in order and compact the rest
        w = 0;
        for (int i = 0; i < N_QUEUE; i++) begin
          if (wait_vld[i]) begin
            if (wait_ip[i] == it.sender_ip) begin
              res = {res, frame(KIND_IPV4, it.sender_mac, '0, '0, wait_tag[i])};
            end else begin
              wait_ip[w]  = wait_ip[i];
              wait_tag[w] = wait_tag[i];
              w++;
            end
          end
        end
        foreach (wait_vld[i]) wait_vld[i] = (i < w);
        if (!it.arp_is_reply)
          res = {res, frame(KIND_REPLY, it.sender_mac, it.sender_ip,
                            it.sender_mac, '0)};
      end
    end else if (it.action == ACT_TICK) begin
      clock_ms = clock_ms + TIME_W'(it.elapsed_ms);
      foreach (arp_vld[i])
        if (arp_vld[i] && clock_ms - arp_time[i] >= lifetime) arp_vld[i] = 0;
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    frames_due = {frames_due, res};
  endtask

  task automatic compare_frame(input out_item_t got);
    out_item_t want;
    bit        bad;
    if (frames_due.size() == 0) begin
      $error("unexpected result: %p", got);
      fail_cnt++;
      return;
    end
    want = frames_due.pop_front();
    bad = 0;
    if (got.frame_kind !== want.frame_kind) begin
      $error("frame_kind: expected %0d, got %0d", want.frame_kind, got.frame_kind);
      bad = 1;
    end
    if (got.dst_mac !== want.dst_mac) begin
      $error("dst_mac: expected %h, got %h", want.dst_mac, got.dst_mac);
      bad = 1;
    end
    if (got.arp_target_ip !== want.arp_target_ip) begin
      $error("arp_target_ip: expected %h, got %h", want.arp_target_ip,
             got.arp_target_ip);
      bad = 1;
    end
    if (got.arp_target_mac !== want.arp_target_mac) begin
      $error("arp_target_mac: expected %h, got %h", want.arp_target_mac,
             got.arp_target_mac);
      bad = 1;
    end
    if (got.out_tag !== want.out_tag) begin
      $error("out_tag: expected %h, got %h", want.out_tag, got.out_tag);
      bad = 1;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, got.last);
      bad = 1;
    end
    if (bad) fail_cnt++;
  endtask

  initial begin
    fail_cnt = 0;
    reset_shadow();
  end

  // watch config, item and result channels
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_shadow();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_MAC:  my_mac   = cfg_wdata;
          CFG_OWN_IP:   my_ip    = cfg_wdata[IP_W-1:0];
          CFG_LIFETIME: lifetime = cfg_wdata[TIME_W-1:0];
          CFG_HOLDOFF:  holdoff  = cfg_wdata[TIME_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) resolve_item(in_item);
      if (out_valid) compare_frame(out_item);
    end
    fails   <= fail_cnt;
    pending <= frames_due.size();
  end

endmodule

### sim/testbench.sv
// Top of the ARP resolver testbench: clock, reset, configuration phases and
// item stimulus. Depends on arpr_pkg, the block and the checker module.
module testbench;
  import arpr_pkg::*;

  localparam int POOL_SZ   = 24;
  localparam int CYC_LIMIT = 400000;

  // action code outside the defined set
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_valid;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MAC_W-1:0]     cfg_wdata;
  int                   fails;
  int                   pending;
  int                   cycles;

  logic [IP_W-1:0]  hop_pool[POOL_SZ];
  logic [MAC_W-1:0] cur_mac;
  logic [IP_W-1:0]  cur_ip;
  int               calm_left;

  arp_resolver_with_pending_queue_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  arp_resolver_with_pending_queue_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .fails(fails),
    .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[MAC_W-1:0];
  endfunction

  // item with every field random; callers overwrite what matters
  function automatic in_item_t noise_item();
    logic [255:0] raw;
    in_item_t     it;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  function automatic in_item_t send_of(logic [IP_W-1:0] ip, logic [TAG_W-1:0] tag);
    in_item_t it;
    it = noise_item();
    it.action       = ACT_SEND;
    it.hop_ip       = ip;
    it.datagram_tag = tag;
    return it;
  endfunction

  function automatic in_item_t arp_of(logic [MAC_W-1:0] dmac, logic reply,
                                      logic [IP_W-1:0] sip, logic [MAC_W-1:0] smac,
                                      logic [IP_W-1:0] tip);
    in_item_t it;
    it = noise_item();
    it.action        = ACT_ARP;
    it.frame_dst_mac = dmac;
    it.arp_is_reply  = reply;
    it.sender_ip     = sip;
    it.sender_mac    = smac;
    it.target_ip     = tip;
    return it;
  endfunction

  function automatic in_item_t tick_of(logic [ELAPSED_W-1:0] ms);
    in_item_t it;
    it = noise_item();
    it.action     = ACT_TICK;
    it.elapsed_ms = ms;
    return it;
  endfunction

  // offer one item after a random gap; returns at the accepting edge
  task automatic offer(input in_item_t it);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 39) == 0) calm_left = 20;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  // hold off until every frame is out and the block has settled
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic set_regs(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip,
                          input logic [TIME_W-1:0] life, input logic [TIME_W-1:0] hold);
    cur_mac = mac;
    cur_ip  = ip;
    cfg_we <= 1'b1;
    cfg_index <= CFG_OWN_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    cfg_index <= CFG_OWN_IP;
    cfg_wdata <= MAC_W'(ip);
    @(posedge clk);
    cfg_index <= CFG_LIFETIME;
    cfg_wdata <= MAC_W'(life);
    @(posedge clk);
    cfg_index <= CFG_HOLDOFF;
    cfg_wdata <= MAC_W'(hold);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random item, weighted toward resolvable traffic
  task automatic random_item();
    int             pick;
    logic [IP_W-1:0] hop;
    in_item_t       it;
    pick = $urandom_range(0, 99);
    hop  = hop_pool[$urandom_range(0, POOL_SZ-1)];
    if (pick < 45) begin
      it = send_of(hop, TAG_W'($urandom));
    end else if (pick < 75) begin
      it = arp_of($urandom_range(0, 1) ? cur_mac : MAC_BCAST, 1'($urandom_range(0, 1)),
                  hop, rand_mac(), cur_ip);
    end else if (pick < 88) begin
      it = tick_of(ELAPSED_W'($urandom_range(0, 9) == 0 ? $urandom
                                                         : $urandom_range(0, 3000)));
    end else if (pick < 94) begin
      it = noise_item();
    end else if (pick < 97) begin
      it = arp_of(rand_mac(), 1'($urandom_range(0, 1)), hop, rand_mac(), cur_ip);
    end else begin
      it = noise_item();
      it.action = ACT_UNUSED;
    end
    offer(it);
  endtask

  initial begin
    logic [TIME_W-1:0] life_set[4];
    logic [TIME_W-1:0] hold_set[4];
    cycles    = 0;
    calm_left = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_OWN_MAC;
    cfg_wdata = '0;
    foreach (hop_pool[i]) hop_pool[i] = $urandom;
    life_set = '{32'd1, 32'hFFFF_FFFF, 32'd4000, LIFETIME_RST};
    hold_set = '{32'd0, 32'hFFFF_FFFF, 32'd1500, HOLDOFF_RST};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (48) @(posedge clk);

    // directed part
    set_regs(rand_mac(), $urandom, LIFETIME_RST, HOLDOFF_RST);
    offer(send_of(hop_pool[0], 16'h0000));
    offer(send_of(hop_pool[0], 16'hFFFF));
    offer(arp_of(MAC_BCAST, 1'b1, hop_pool[0], rand_mac(), cur_ip));
    offer(send_of(hop_pool[0], 16'h1234));
    offer(arp_of(cur_mac, 1'b0, hop_pool[1], 48'hFFFF_FFFF_FFFF, cur_ip));
    offer(arp_of(cur_mac, 1'b0, hop_pool[2], 48'h0, ~cur_ip));
    offer(arp_of(~cur_mac, 1'b1, hop_pool[2], rand_mac(), cur_ip));
    offer(tick_of(16'h0000));
    offer(tick_of(16'hFFFF));
    offer(send_of(32'h0000_0000, 16'h00FF));
    offer(send_of(32'hFFFF_FFFF, 16'hFF00));
    begin
      in_item_t odd;
      odd = noise_item();
      odd.action = ACT_UNUSED;
      offer(odd);
    end
    // overfill the pending queue so the last sends are dropped
    for (int i = 0; i < 16; i++) offer(send_of(hop_pool[3 + i % 6], TAG_W'($urandom)));
    drain();

    // random phases, each under a different register setting
    for (int p = 0; p < 4; p++) begin
      set_regs(p == 3 ? 48'h0 : rand_mac(), p == 3 ? 32'h0 : $urandom,
               life_set[p], hold_set[p]);
      for (int n = 0; n < 75; n++) begin
        random_item();
        if (p == 1 && n == 37) drain();
      end
      drain();
    end

    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
